@@ rtl/tfa_pkg.sv @@
// Shared constants, types and helpers for the thermocouple frame averager.
`timescale 1ns / 1ps

package tfa_pkg;

    localparam int WINDOW_SIZE  = 8;
    localparam int COUNTER_BITS = 16;

    localparam int FRAME_W      = 32;
    localparam int TEMP_W       = 18;
    localparam int FLAG_W       = 3;
    localparam int TALLY_OUT_W  = 4;
    localparam int CNT_OUT_W    = 16;
    localparam int RAW_TEMP_W   = 14;
    localparam int RAW_TEMP_LSB = 18;
    localparam int SCALE_SHIFT  = 4;

    localparam int SUM_W     = RAW_TEMP_W + $clog2(WINDOW_SIZE);
    localparam int TALLY_W   = $clog2(WINDOW_SIZE + 1);
    localparam int POS_W     = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int NUM_W     = SUM_W + SCALE_SHIFT;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [FRAME_W-1:0]       RESERVED_MASK  = 32'h0002_0008;
    localparam logic signed [TEMP_W-1:0] FALLBACK_RESET = 18'sd128000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } fsm_state_t;

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

@@ rtl/tfa_divider.sv @@
// Bit-serial restoring divider for the window mean, one quotient bit per cycle.
`timescale 1ns / 1ps

module tfa_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tfa_pkg::NUM_W-1:0]   dividend,
    input  logic [tfa_pkg::TALLY_W-1:0] divisor,
    output logic                       done,
    output logic [tfa_pkg::NUM_W-1:0]   quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [tfa_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [tfa_pkg::TALLY_W-1:0]     rem_reg, rem_next;
    logic [tfa_pkg::TALLY_W-1:0]     dsr_reg, dsr_next;
    logic [tfa_pkg::NUM_W-1:0]       quo_reg, quo_next;
    logic [tfa_pkg::TALLY_W:0]       rem_shift;
    logic [tfa_pkg::TALLY_W:0]       rem_sub;
    logic                            fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[tfa_pkg::NUM_W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        rem_sub   = rem_shift - {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[tfa_pkg::TALLY_W-1:0] : rem_shift[tfa_pkg::TALLY_W-1:0];
            quo_next = {quo_reg[tfa_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tfa_pkg::DIV_CNT_W'(tfa_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/thermocouple_frame_averager.sv @@
// Top level: frame checking, window accumulation, counters and result register.
`timescale 1ns / 1ps

// Takes one 32-bit converter word per accepted input. Words that do not close a
// window are absorbed while the block stays idle, so such words can be taken back
// to back. The word that closes a window with at least one valid sample starts the
// bit-serial divider, one quotient bit per cycle: at the default window of 8 that
// is 21 bits, and in_ready stays low while the divider runs and until the result
// is loaded into the output register. A window with no valid sample skips the
// divider and holds in_ready low only until that load. The load waits while the
// output register still holds a result not yet taken by out_ready, and in_ready
// stays low meanwhile.

module thermocouple_frame_averager (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic signed [tfa_pkg::TEMP_W-1:0]   cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tfa_pkg::FRAME_W-1:0]         raw_frame,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tfa_pkg::TEMP_W-1:0]   temperature,
    output logic [tfa_pkg::FLAG_W-1:0]          fault_flags,
    output logic [tfa_pkg::TALLY_OUT_W-1:0]     valid_samples,
    output logic [tfa_pkg::CNT_OUT_W-1:0]       rejected_total,
    output logic [tfa_pkg::CNT_OUT_W-1:0]       faulty_total,
    output logic [tfa_pkg::CNT_OUT_W-1:0]       invalid_average_total
);

    tfa_pkg::fsm_state_t state_reg, state_next;

    logic signed [tfa_pkg::TEMP_W-1:0]   fallback_reg;
    logic signed [tfa_pkg::SUM_W-1:0]    sum_reg, sum_next, sum_acc;
    logic [tfa_pkg::TALLY_W-1:0]         tally_reg, tally_next, tally_acc;
    logic [tfa_pkg::FLAG_W-1:0]          flags_reg, flags_next, flags_acc;
    logic [tfa_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [tfa_pkg::COUNTER_BITS-1:0]    rej_cnt_reg, rej_cnt_next;
    logic [tfa_pkg::COUNTER_BITS-1:0]    flt_cnt_reg, flt_cnt_next;
    logic [tfa_pkg::COUNTER_BITS-1:0]    inv_cnt_reg, inv_cnt_next;

    logic signed [tfa_pkg::TEMP_W-1:0]   res_temp_reg, res_temp_next;
    logic [tfa_pkg::FLAG_W-1:0]          res_flags_reg, res_flags_next;
    logic [tfa_pkg::TALLY_W-1:0]         res_tally_reg, res_tally_next;
    logic                                neg_reg, neg_next;

    logic                                out_valid_reg, out_valid_next;
    logic signed [tfa_pkg::TEMP_W-1:0]   out_temp_reg;
    logic [tfa_pkg::FLAG_W-1:0]          out_flags_reg;
    logic [tfa_pkg::TALLY_OUT_W-1:0]     out_tally_reg;
    logic [tfa_pkg::CNT_OUT_W-1:0]       out_rej_reg;
    logic [tfa_pkg::CNT_OUT_W-1:0]       out_flt_reg;
    logic [tfa_pkg::CNT_OUT_W-1:0]       out_inv_reg;
    logic                                out_load;

    logic signed [tfa_pkg::RAW_TEMP_W-1:0] frame_temp;
    logic                                is_rej;
    logic                                is_flt;
    logic                                accept;
    logic                                win_end;
    logic [tfa_pkg::SUM_W-1:0]           sum_mag;
    logic                                div_start;
    logic                                div_done;
    logic [tfa_pkg::NUM_W-1:0]           div_quo;
    logic signed [tfa_pkg::NUM_W:0]      quo_signed;
    logic signed [tfa_pkg::NUM_W:0]      mean_signed;

    tfa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_mag, {tfa_pkg::SCALE_SHIFT{1'b0}}}),
        .divisor  (tally_acc),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign frame_temp = $signed(raw_frame[tfa_pkg::FRAME_W-1:tfa_pkg::RAW_TEMP_LSB]);
    assign is_rej     = |(raw_frame & tfa_pkg::RESERVED_MASK);
    assign is_flt     = |raw_frame[tfa_pkg::FLAG_W-1:0];
    assign in_ready   = (state_reg == tfa_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign win_end    = (pos_reg == tfa_pkg::POS_W'(tfa_pkg::WINDOW_SIZE - 1));

    always_comb
    begin
        sum_acc   = sum_reg;
        tally_acc = tally_reg;
        flags_acc = flags_reg;
        if (!is_rej && is_flt)
        begin
            flags_acc = flags_reg | raw_frame[tfa_pkg::FLAG_W-1:0];
        end
        else if (!is_rej)
        begin
            sum_acc   = sum_reg + tfa_pkg::SUM_W'(frame_temp);
            tally_acc = tally_reg + 1'b1;
        end
        sum_mag = sum_acc[tfa_pkg::SUM_W-1] ? tfa_pkg::SUM_W'(-sum_acc)
                                            : tfa_pkg::SUM_W'(sum_acc);
    end

    assign quo_signed  = $signed({1'b0, div_quo});
    assign mean_signed = neg_reg ? -quo_signed : quo_signed;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        tally_next     = tally_reg;
        flags_next     = flags_reg;
        pos_next       = pos_reg;
        rej_cnt_next   = rej_cnt_reg;
        flt_cnt_next   = flt_cnt_reg;
        inv_cnt_next   = inv_cnt_reg;
        res_temp_next  = res_temp_reg;
        res_flags_next = res_flags_reg;
        res_tally_next = res_tally_reg;
        neg_next       = neg_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            tfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_rej)
                    begin
                        rej_cnt_next = tfa_pkg::sat_inc(rej_cnt_reg);
                    end
                    else if (is_flt)
                    begin
                        flt_cnt_next = tfa_pkg::sat_inc(flt_cnt_reg);
                    end

                    if (win_end)
                    begin
                        pos_next       = '0;
                        sum_next       = '0;
                        tally_next     = '0;
                        flags_next     = '0;
                        res_tally_next = tally_acc;
                        if (tally_acc != '0)
                        begin
                            div_start      = 1'b1;
                            neg_next       = sum_acc[tfa_pkg::SUM_W-1];
                            res_flags_next = '0;
                            state_next     = tfa_pkg::ST_DIV;
                        end
                        else
                        begin
                            res_temp_next  = fallback_reg;
                            res_flags_next = flags_acc;
                            inv_cnt_next   = tfa_pkg::sat_inc(inv_cnt_reg);
                            state_next     = tfa_pkg::ST_EMIT;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        sum_next   = sum_acc;
                        tally_next = tally_acc;
                        flags_next = flags_acc;
                    end
                end
            end
            tfa_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_temp_next = tfa_pkg::TEMP_W'(mean_signed);
                    state_next    = tfa_pkg::ST_EMIT;
                end
            end
            tfa_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = tfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tfa_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfa_pkg::ST_IDLE;
            fallback_reg  <= tfa_pkg::FALLBACK_RESET;
            sum_reg       <= '0;
            tally_reg     <= '0;
            flags_reg     <= '0;
            pos_reg       <= '0;
            rej_cnt_reg   <= '0;
            flt_cnt_reg   <= '0;
            inv_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                fallback_reg <= cfg_wdata;
            end
            sum_reg       <= sum_next;
            tally_reg     <= tally_next;
            flags_reg     <= flags_next;
            pos_reg       <= pos_next;
            rej_cnt_reg   <= rej_cnt_next;
            flt_cnt_reg   <= flt_cnt_next;
            inv_cnt_reg   <= inv_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_temp_reg  <= res_temp_next;
        res_flags_reg <= res_flags_next;
        res_tally_reg <= res_tally_next;
        neg_reg       <= neg_next;
        if (out_load)
        begin
            out_temp_reg  <= res_temp_reg;
            out_flags_reg <= res_flags_reg;
            out_tally_reg <= tfa_pkg::TALLY_OUT_W'(res_tally_reg);
            out_rej_reg   <= tfa_pkg::CNT_OUT_W'(rej_cnt_reg);
            out_flt_reg   <= tfa_pkg::CNT_OUT_W'(flt_cnt_reg);
            out_inv_reg   <= tfa_pkg::CNT_OUT_W'(inv_cnt_reg);
        end
    end

    assign out_valid             = out_valid_reg;
    assign temperature           = out_temp_reg;
    assign fault_flags           = out_flags_reg;
    assign valid_samples         = out_tally_reg;
    assign rejected_total        = out_rej_reg;
    assign faulty_total          = out_flt_reg;
    assign invalid_average_total = out_inv_reg;

    // divider is only launched from idle and only finishes while waited on
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == tfa_pkg::ST_IDLE))
        else $error("divider started outside idle");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == tfa_pkg::ST_DIV))
        else $error("divider finished while not waited on");

    a_window_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && win_end) |=> (pos_reg == '0 && tally_reg == '0 && sum_reg == '0))
        else $error("window state not cleared at window end");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= tfa_pkg::POS_W'(tfa_pkg::WINDOW_SIZE - 1))
        else $error("window position out of range");

    a_flags_no_samples: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_flags_reg != '0) |-> (res_tally_reg == '0))
        else $error("fault flags reported with valid samples");

endmodule

@@ sim/tb_top.sv @@
// Testbench for the thermocouple frame averager: directed table, random windows, stalls.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_CYCLES      = 300;
    localparam int SETTLE_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int RANDOM_WINDOWS    = 17;
    localparam int RANDOM_PHASES     = 4;
    localparam int FLAT_OUT_WINDOWS  = 10;
    localparam int DIRECTED_ROWS     = 24;

    typedef enum int {
        KIND_VALID,
        KIND_FAULT,
        KIND_REJECT,
        KIND_NOISE
    } frame_kind_t;

    typedef struct packed {
        logic signed [tfa_pkg::TEMP_W-1:0]  temperature;
        logic [tfa_pkg::FLAG_W-1:0]         flags;
        logic [tfa_pkg::TALLY_OUT_W-1:0]    valid;
        logic [tfa_pkg::CNT_OUT_W-1:0]      rejected;
        logic [tfa_pkg::CNT_OUT_W-1:0]      faulty;
        logic [tfa_pkg::CNT_OUT_W-1:0]      invalid_windows;
    } window_result_t;

    typedef struct packed {
        logic [tfa_pkg::FRAME_W-1:0] frame;
        bit                          typed;
        window_result_t              want;
    } directed_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic signed [tfa_pkg::TEMP_W-1:0]   cfg_wdata;
    logic                                in_valid;
    logic                                in_ready;
    logic [tfa_pkg::FRAME_W-1:0]         raw_frame;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [tfa_pkg::TEMP_W-1:0]   temperature;
    logic [tfa_pkg::FLAG_W-1:0]          fault_flags;
    logic [tfa_pkg::TALLY_OUT_W-1:0]     valid_samples;
    logic [tfa_pkg::CNT_OUT_W-1:0]       rejected_total;
    logic [tfa_pkg::CNT_OUT_W-1:0]       faulty_total;
    logic [tfa_pkg::CNT_OUT_W-1:0]       invalid_average_total;

    // predictor state
    logic signed [tfa_pkg::TEMP_W-1:0]   fallback_temp = tfa_pkg::FALLBACK_RESET;
    logic signed [tfa_pkg::SUM_W-1:0]    quarter_sum = '0;
    logic [tfa_pkg::TALLY_W-1:0]         valid_count = '0;
    logic [tfa_pkg::FLAG_W-1:0]          window_fault_or = '0;
    int                                  frames_in_window = 0;
    logic [tfa_pkg::CNT_OUT_W-1:0]       rejected_count = '0;
    logic [tfa_pkg::CNT_OUT_W-1:0]       faulty_count = '0;
    logic [tfa_pkg::CNT_OUT_W-1:0]       empty_window_count = '0;

    window_result_t expected_windows [$];

    bit idle_on = 1'b1;
    bit stall_request = 1'b0;
    int frames_sent = 0;
    int windows_checked = 0;
    int fallback_writes = 0;
    int mismatches = 0;

    // max, reserved and fault mixes, min
    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        {32'h7FFC0000, 1'b0, 73'd0},
        {32'h7FFDFFF0, 1'b0, 73'd0},
        {32'h7FFC0000, 1'b0, 73'd0},
        {32'h7FFD0000, 1'b0, 73'd0},
        {32'h7FFC8880, 1'b0, 73'd0},
        {32'h7FFC0000, 1'b0, 73'd0},
        {32'h7FFC0000, 1'b0, 73'd0},
        {32'h7FFDFFF0, 1'b1, {18'd131056, 3'd0, 4'd8, 16'd0, 16'd0, 16'd0}},
        {32'h00000008, 1'b0, 73'd0},
        {32'h00020000, 1'b0, 73'd0},
        {32'h0000000C, 1'b0, 73'd0},
        {32'h00020004, 1'b0, 73'd0},
        {32'h00000001, 1'b0, 73'd0},
        {32'h80000002, 1'b0, 73'd0},
        {32'h00000003, 1'b0, 73'd0},
        {32'h00010001, 1'b1, {18'd128000, 3'd3, 4'd0, 16'd4, 16'd4, 16'd1}},
        {32'h80000000, 1'b0, 73'd0},
        {32'h80000004, 1'b0, 73'd0},
        {32'h80010000, 1'b0, 73'd0},
        {32'h8000FFF0, 1'b0, 73'd0},
        {32'h80000000, 1'b0, 73'd0},
        {32'h80000000, 1'b0, 73'd0},
        {32'h80000000, 1'b0, 73'd0},
        {32'h80000000, 1'b1, {18'h20000, 3'd0, 4'd7, 16'd4, 16'd5, 16'd1}}
    };

    thermocouple_frame_averager dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .raw_frame             (raw_frame),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .temperature           (temperature),
        .fault_flags           (fault_flags),
        .valid_samples         (valid_samples),
        .rejected_total        (rejected_total),
        .faulty_total          (faulty_total),
        .invalid_average_total (invalid_average_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [tfa_pkg::CNT_OUT_W-1:0] bump(
        input logic [tfa_pkg::CNT_OUT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic accumulate_frame(input logic [tfa_pkg::FRAME_W-1:0] raw, output bit closes,
                                    output window_result_t res);
        logic signed [tfa_pkg::RAW_TEMP_W-1:0] quarter;
        int scaled;
        quarter = raw[tfa_pkg::FRAME_W-1:tfa_pkg::RAW_TEMP_LSB];
        res = '0;
        if ((raw & tfa_pkg::RESERVED_MASK) != '0)
            rejected_count = bump(rejected_count);
        else if (raw[tfa_pkg::FLAG_W-1:0] != '0)
        begin
            faulty_count = bump(faulty_count);
            window_fault_or |= raw[tfa_pkg::FLAG_W-1:0];
        end
        else
        begin
            quarter_sum += quarter;
            valid_count++;
        end
        frames_in_window++;
        closes = (frames_in_window == tfa_pkg::WINDOW_SIZE);
        if (closes)
        begin
            if (valid_count != '0)
            begin
                scaled = (int'(quarter_sum) * 16) / int'(valid_count);
                res.temperature = scaled[tfa_pkg::TEMP_W-1:0];
                res.flags = '0;
            end
            else
            begin
                empty_window_count = bump(empty_window_count);
                res.temperature = fallback_temp;
                res.flags = window_fault_or;
            end
            res.valid = valid_count[tfa_pkg::TALLY_OUT_W-1:0];
            res.rejected = rejected_count;
            res.faulty = faulty_count;
            res.invalid_windows = empty_window_count;
            quarter_sum = '0;
            valid_count = '0;
            window_fault_or = '0;
            frames_in_window = 0;
        end
    endtask

    // starts and ends at a falling edge; valid stays up for a following word
    task automatic send_frame(input logic [tfa_pkg::FRAME_W-1:0] raw, input bit typed,
                              input window_result_t typed_want);
        bit closes;
        window_result_t res;
        while (idle_on && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        raw_frame <= raw;
        do @(posedge clk); while (!in_ready);
        accumulate_frame(raw, closes, res);
        frames_sent++;
        if (closes)
            expected_windows.push_back(typed ? typed_want : res);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_windows.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_fallback(input logic [tfa_pkg::TEMP_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        fallback_temp = value;
        fallback_writes++;
    endtask

    function automatic logic [tfa_pkg::FRAME_W-1:0] random_frame(input frame_kind_t kind);
        logic [tfa_pkg::FRAME_W-1:0] f;
        f = $urandom;
        case (kind)
            KIND_VALID:
            begin
                f &= ~(tfa_pkg::RESERVED_MASK | 32'h7);
                if ($urandom_range(99) < 30)
                    f[tfa_pkg::FRAME_W-1:tfa_pkg::RAW_TEMP_LSB] =
                        14'($urandom_range(0, 31)) - 14'd16;
            end
            KIND_FAULT:
            begin
                f &= ~tfa_pkg::RESERVED_MASK;
                if (f[tfa_pkg::FLAG_W-1:0] == '0)
                    f[tfa_pkg::FLAG_W-1:0] = 3'($urandom_range(1, 7));
            end
            KIND_REJECT:
                if ((f & tfa_pkg::RESERVED_MASK) == '0)
                    f |= $urandom_range(1) ? 32'h0000_0008 : 32'h0002_0000;
            default: ;
        endcase
        return f;
    endfunction

    task automatic run_windows(input int count);
        int mode;
        int pick;
        frame_kind_t kind;
        for (int w = 0; w < count; w++)
        begin
            mode = $urandom_range(99);
            for (int i = 0; i < tfa_pkg::WINDOW_SIZE; i++)
            begin
                pick = $urandom_range(99);
                if (mode < 15)
                    kind = pick < 50 ? KIND_FAULT : KIND_REJECT;
                else if (mode < 30)
                    kind = KIND_VALID;
                else if (pick < 60)
                    kind = KIND_VALID;
                else if (pick < 78)
                    kind = KIND_FAULT;
                else if (pick < 92)
                    kind = KIND_REJECT;
                else
                    kind = KIND_NOISE;
                send_frame(random_frame(kind), 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !(idle_on && $urandom_range(99) < 6);
        end
    end

    always @(posedge clk)
    begin
        window_result_t seen;
        window_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {temperature, fault_flags, valid_samples, rejected_total,
                    faulty_total, invalid_average_total};
            if (expected_windows.size() == 0)
            begin
                $error("result with no window pending: temperature %0d",
                       $signed(seen.temperature));
                mismatches++;
            end
            else
            begin
                want = expected_windows.pop_front();
                windows_checked++;
                if (seen.temperature !== want.temperature)
                begin
                    $error("temperature: expected %0d, got %0d",
                           $signed(want.temperature), $signed(seen.temperature));
                    mismatches++;
                end
                if (seen.flags !== want.flags)
                begin
                    $error("fault_flags: expected %0d, got %0d", want.flags, seen.flags);
                    mismatches++;
                end
                if (seen.valid !== want.valid)
                begin
                    $error("valid_samples: expected %0d, got %0d", want.valid, seen.valid);
                    mismatches++;
                end
                if (seen.rejected !== want.rejected)
                begin
                    $error("rejected_total: expected %0d, got %0d",
                           want.rejected, seen.rejected);
                    mismatches++;
                end
                if (seen.faulty !== want.faulty)
                begin
                    $error("faulty_total: expected %0d, got %0d", want.faulty, seen.faulty);
                    mismatches++;
                end
                if (seen.invalid_windows !== want.invalid_windows)
                begin
                    $error("invalid_average_total: expected %0d, got %0d",
                           want.invalid_windows, seen.invalid_windows);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d windows outstanding",
                 WATCHDOG_LIMIT, expected_windows.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [tfa_pkg::TEMP_W-1:0] fallback_choice;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        raw_frame = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset fallback in force here
        foreach (directed_rows[r])
            send_frame(directed_rows[r].frame, directed_rows[r].typed, directed_rows[r].want);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: fallback_choice = 18'h20000;
                1: fallback_choice = 18'h1FFFF;
                2: fallback_choice = '0;
                default: fallback_choice = tfa_pkg::TEMP_W'($urandom);
            endcase
            write_fallback(fallback_choice);
            if (p == 1)
                stall_request = 1'b1;
            run_windows(RANDOM_WINDOWS);
            drain_results();
        end

        idle_on = 1'b0;
        write_fallback(tfa_pkg::TEMP_W'($urandom));
        run_windows(FLAT_OUT_WINDOWS);
        drain_results();
        idle_on = 1'b1;

        $display("covered %0d frames and %0d windows under %0d fallback settings,",
                 frames_sent, windows_checked, fallback_writes);
        $display("incl. a long output stall and a stretch with both sides never idle");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ thermocouple_frame_averager.f @@
rtl/tfa_pkg.sv
rtl/tfa_divider.sv
rtl/thermocouple_frame_averager.sv
sim/tb_top.sv
